// ===== src/txtcon_pkg.sv =====
// ----------------------------------------------------------------------------
// txtcon_pkg
// shared types and constants for the text console with cursor and scroll
// ----------------------------------------------------------------------------
package txtcon_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CHAR    = 8'h0a;
    localparam logic [7:0] BLANK_CHAR      = 8'h20;
    localparam logic [7:0] RESET_ATTRIBUTE = 8'h07;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_BLANK,
        S_DONE
    } state_t;

endpackage

// ===== src/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// text-mode console: cell store with cursor, line wrap, scroll, clear and read
// ----------------------------------------------------------------------------
// The cell store is one single-port-write, single-port-read memory of
// COLUMNS*ROWS 16-bit cells. After reset a clearing pass fills the store
// with blanks before the first input transfer is taken (configuration writes
// are taken during it). A put of an ordinary character, a newline without
// scroll, a read and the unused kind go from S_IDLE straight to S_DONE,
// which loads the result into the output register once that is free. A put
// that scrolls copies every row up and blanks the bottom row. A clear
// blanks every cell. One item is worked on at a time; the result sits in
// an output register so the next input transfer can be taken while it
// waits.
module text_console_cursor_scroll #(
    parameter int COLUMNS = txtcon_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = txtcon_pkg::DEFAULT_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  character,
    input  logic [10:0] cell_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] cell_value,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_line
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(CELL_COUNT + 1);
    localparam int COLW       = $clog2(COLUMNS);
    localparam int LINW       = $clog2(ROWS);

    localparam logic [CW-1:0]   CELLS_C     = CW'(CELL_COUNT);
    localparam logic [CW-1:0]   LAST_CELL_C = CW'(CELL_COUNT - 1);
    localparam logic [CW-1:0]   COLUMNS_CW  = CW'(COLUMNS);
    localparam logic [AW-1:0]   COLUMNS_AW  = AW'(COLUMNS);
    localparam logic [AW-1:0]   BOTTOM_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [COLW-1:0] LAST_COL    = COLW'(COLUMNS - 1);
    localparam logic [LINW-1:0] LAST_LINE   = LINW'(ROWS - 1);

    txtcon_pkg::state_t state_reg, state_next;

    logic [7:0]      attr_reg;
    logic [COLW-1:0] col_reg, col_next;
    logic [LINW-1:0] line_reg, line_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [CW-1:0]   src_reg, src_next;
    logic [CW-1:0]   dst_reg, dst_next;
    logic            pend_reg, pend_next;
    logic            rd_hit_reg, rd_hit_next;

    logic            out_valid_reg, out_valid_next;
    logic [15:0]     cell_value_reg, cell_value_next;
    logic [6:0]      cursor_column_reg, cursor_column_next;
    logic [4:0]      cursor_line_reg, cursor_line_next;

    logic [15:0]     mem [CELL_COUNT];
    logic [15:0]     rd_data_reg;
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [15:0]     wr_data;

    logic            in_xfer;
    logic            out_free;
    logic            cursor_eol;

    assign in_ready      = (state_reg == txtcon_pkg::S_IDLE);
    assign in_xfer       = in_valid && in_ready;
    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign cell_value    = cell_value_reg;
    assign cursor_column = cursor_column_reg;
    assign cursor_line   = cursor_line_reg;

    // cell store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= txtcon_pkg::RESET_ATTRIBUTE;
        end
        else if (cfg_wr_en)
        begin
            attr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= txtcon_pkg::S_INIT;
            col_reg           <= '0;
            line_reg          <= '0;
            base_reg          <= '0;
            src_reg           <= '0;
            dst_reg           <= '0;
            pend_reg          <= 1'b0;
            rd_hit_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            cursor_column_reg <= '0;
            cursor_line_reg   <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            col_reg           <= col_next;
            line_reg          <= line_next;
            base_reg          <= base_next;
            src_reg           <= src_next;
            dst_reg           <= dst_next;
            pend_reg          <= pend_next;
            rd_hit_reg        <= rd_hit_next;
            out_valid_reg     <= out_valid_next;
            cursor_column_reg <= cursor_column_next;
            cursor_line_reg   <= cursor_line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_value_reg <= cell_value_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        col_next           = col_reg;
        line_next          = line_reg;
        base_next          = base_reg;
        src_next           = src_reg;
        dst_next           = dst_reg;
        pend_next          = pend_reg;
        rd_hit_next        = rd_hit_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        cell_value_next    = cell_value_reg;
        cursor_column_next = cursor_column_reg;
        cursor_line_next   = cursor_line_reg;
        wr_en              = 1'b0;
        wr_addr            = dst_reg[AW-1:0];
        wr_data            = {attr_reg, txtcon_pkg::BLANK_CHAR};
        rd_en              = 1'b0;
        rd_addr            = src_reg[AW-1:0];
        cursor_eol         = 1'b0;

        unique case (state_reg)
            txtcon_pkg::S_INIT:
            begin
                wr_en    = 1'b1;
                wr_data  = {txtcon_pkg::RESET_ATTRIBUTE, txtcon_pkg::BLANK_CHAR};
                dst_next = dst_reg + 1'b1;
                if (dst_reg == LAST_CELL_C)
                begin
                    state_next = txtcon_pkg::S_IDLE;
                end
            end

            txtcon_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    rd_hit_next = 1'b0;
                    state_next  = txtcon_pkg::S_DONE;
                    unique case (kind)
                        txtcon_pkg::KIND_PUT:
                        begin
                            if (character == txtcon_pkg::NEWLINE_CHAR)
                            begin
                                cursor_eol = 1'b1;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = base_reg + AW'(col_reg);
                                wr_data = {attr_reg, character};
                                if (col_reg == LAST_COL)
                                begin
                                    cursor_eol = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                            if (cursor_eol)
                            begin
                                col_next = '0;
                                if (line_reg == LAST_LINE)
                                begin
                                    src_next   = COLUMNS_CW;
                                    dst_next   = '0;
                                    pend_next  = 1'b0;
                                    state_next = txtcon_pkg::S_SCROLL;
                                end
                                else
                                begin
                                    line_next = line_reg + 1'b1;
                                    base_next = base_reg + COLUMNS_AW;
                                end
                            end
                        end
                        txtcon_pkg::KIND_CLEAR:
                        begin
                            col_next   = '0;
                            line_next  = '0;
                            base_next  = '0;
                            dst_next   = '0;
                            state_next = txtcon_pkg::S_BLANK;
                        end
                        txtcon_pkg::KIND_READ:
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = AW'(cell_index);
                            rd_hit_next = (32'(cell_index) < 32'(CELL_COUNT));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            txtcon_pkg::S_SCROLL:
            begin
                // source runs one cell ahead of the write-back
                if (src_reg < CELLS_C)
                begin
                    rd_en    = 1'b1;
                    src_next = src_reg + 1'b1;
                end
                pend_next = (src_reg < CELLS_C);
                if (pend_reg)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data_reg;
                    dst_next = dst_reg + 1'b1;
                end
                if (!pend_reg && src_reg == CELLS_C)
                begin
                    base_next  = BOTTOM_BASE;
                    state_next = txtcon_pkg::S_BLANK;
                end
            end

            txtcon_pkg::S_BLANK:
            begin
                wr_en    = 1'b1;
                dst_next = dst_reg + 1'b1;
                if (dst_reg == LAST_CELL_C)
                begin
                    state_next = txtcon_pkg::S_DONE;
                end
            end

            txtcon_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    cell_value_next    = rd_hit_reg ? rd_data_reg : 16'h0000;
                    cursor_column_next = 7'(col_reg);
                    cursor_line_next   = 5'(line_reg);
                    state_next         = txtcon_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = txtcon_pkg::S_IDLE;
            end
        endcase
    end

endmodule
